/* design/usb_transfer_descriptor_splitter_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the transfer descriptor splitter
// Shared implication and invariant forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef USB_TRANSFER_DESCRIPTOR_SPLITTER_CORE_ASSERT_SVH
`define USB_TRANSFER_DESCRIPTOR_SPLITTER_CORE_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define UTDS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold in the same cycle.
`define UTDS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/utds_pkg.sv */
// ----------------------------------------------------------------------------
// utds_pkg
// Types and constants of the transfer descriptor splitter.
// ----------------------------------------------------------------------------
package utds_pkg;

  localparam int LAST_BUFFER_INDEX = 4;
  localparam int PAGE_BYTES        = 4096;
  localparam int LEN_BITS          = 18;
  localparam int MAX_RESULTS       = 20;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int ADDR_W    = 64;
  localparam int MP_W      = 11;
  localparam int BC_W      = 15;
  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int SPAN_MAX  = (LAST_BUFFER_INDEX + 1) * PAGE_BYTES;
  localparam int SPAN_W    = $clog2(SPAN_MAX + 1);
  localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int SETUP_BYTES = 8;

  // token codes
  localparam logic [1:0] PID_OUT   = 2'd0;
  localparam logic [1:0] PID_IN    = 2'd1;
  localparam logic [1:0] PID_SETUP = 2'd2;

  // short-read alternate link codes
  localparam logic [1:0] ALT_TERM   = 2'd0;
  localparam logic [1:0] ALT_STOP   = 2'd1;
  localparam logic [1:0] ALT_STATUS = 2'd2;

  typedef struct packed {
    logic              is_control;
    logic              is_in;
    logic [ADDR_W-1:0] setup_addr;
    logic [ADDR_W-1:0] data_addr;
    logic [LEN_BITS-1:0] data_len;
    logic [MP_W-1:0]   max_packet;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        pid_code;
    logic              data_toggle;
    logic [ADDR_W-1:0] buffer_start;
    logic [BC_W-1:0]   byte_count;
    logic [1:0]        alt_link;
    logic              last;
  } out_item_t;

  // classified request as queued between front and back
  typedef struct packed {
    logic              is_control;
    logic              is_in;
    logic [1:0]        alt_link;
    logic [ADDR_W-1:0] setup_addr;
    logic [ADDR_W-1:0] data_addr;
    logic [LEN_BITS-1:0] data_len;
    logic [MP_W-1:0]   max_packet;
  } job_t;

endpackage

/* design/utds_div.sv */
// ----------------------------------------------------------------------------
// utds_div
// Restoring divider, one quotient bit per cycle: chunk length by max packet.
// ----------------------------------------------------------------------------
module utds_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [utds_pkg::SPAN_W-1:0] dividend,
  input  logic [utds_pkg::MP_W-1:0]   divisor,
  output logic                       busy,
  output logic                       done,
  output logic [utds_pkg::SPAN_W-1:0] quotient,
  output logic [utds_pkg::MP_W-1:0]   remainder
);
  import utds_pkg::*;

  localparam int STEP_W = $clog2(SPAN_W + 1);

  logic [SPAN_W-1:0] quo;
  logic [MP_W-1:0]   rem_acc;
  logic [MP_W-1:0]   dsr;
  logic [STEP_W-1:0] steps;
  logic [MP_W:0]     partial;
  logic [MP_W:0]     diff;
  logic              ge;
  logic [MP_W-1:0]   rem_step;

  always_comb begin
    partial  = {rem_acc, quo[SPAN_W-1]};
    diff     = partial - {1'b0, dsr};
    ge       = (partial >= {1'b0, dsr});
    rem_step = ge ? diff[MP_W-1:0] : partial[MP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo     <= dividend;
        rem_acc <= '0;
        dsr     <= divisor;
        steps   <= STEP_W'(SPAN_W);
        busy    <= 1'b1;
      end else if (busy) begin
        quo     <= {quo[SPAN_W-2:0], ge};
        rem_acc <= rem_step;
        steps   <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem_acc;

endmodule

/* design/utds_front.sv */
// ----------------------------------------------------------------------------
// utds_front
// Accepts requests, classifies them and queues the ones that give descriptors.
// ----------------------------------------------------------------------------
module utds_front #(
  parameter int QUEUE_DEPTH = utds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  utds_pkg::in_item_t req,
  output logic               q_valid,
  input  logic               q_pop,
  output utds_pkg::job_t     q_job
);
  import utds_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  job_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  job_t              job;
  logic              drop;
  logic              accept;
  logic              push;

  // classify: token direction link, max packet fix-up, empty bulk drop
  always_comb begin
    job.is_control = req.is_control;
    job.is_in      = req.is_in;
    job.setup_addr = req.setup_addr;
    job.data_addr  = req.data_addr;
    job.data_len   = req.data_len;
    job.max_packet = (req.max_packet == '0) ? MP_W'(1) : req.max_packet;
    if (req.is_in) begin
      job.alt_link = req.is_control ? ALT_STATUS : ALT_STOP;
    end else begin
      job.alt_link = ALT_TERM;
    end
    drop = !req.is_control && (req.data_len == '0);
  end

  assign req_stall = (fill == FILL_W'(QUEUE_DEPTH));
  assign accept    = req_valid && !req_stall;
  assign push      = accept && !drop;
  assign q_valid   = (fill != '0);
  assign q_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* design/utds_back.sv */
// ----------------------------------------------------------------------------
// utds_back
// Descriptor sequencer: setup, page-bounded data chunks, status.
// ----------------------------------------------------------------------------
`include "usb_transfer_descriptor_splitter_core_assert.svh"

module utds_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  utds_pkg::job_t      q_job,
  output logic                q_pop,
  output logic                desc_valid,
  input  logic                desc_stall,
  output utds_pkg::out_item_t desc
);
  import utds_pkg::*;

  localparam int CMP_W = (LEN_BITS > SPAN_W) ? LEN_BITS : SPAN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_START, S_DIV, S_EMIT, S_STATUS
  } state_t;

  state_t            state, state_next;
  job_t              job_r, job_r_next;
  logic [LEN_BITS-1:0] done, done_next;
  logic [CNT_W-1:0]  n, n_next;
  logic              toggle, toggle_next;
  logic [ADDR_W-1:0] cur_addr, cur_addr_next;
  logic [SPAN_W-1:0] l0, l0_next;
  logic              fits, fits_next;
  logic              desc_valid_next;
  out_item_t         desc_next;

  logic              out_free;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  n_inc;
  logic              more;
  logic [LEN_BITS-1:0] rem;
  logic [SPAN_W-1:0] span;
  logic              rem_fits;
  logic [SPAN_W-1:0] len;
  logic              odd;
  logic [LEN_BITS-1:0] done_sum;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [SPAN_W-1:0] div_quo;
  logic [MP_W-1:0]   div_rem;

  utds_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (l0_next),
    .divisor   (job_r.max_packet),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    out_free = !desc_valid || !desc_stall;
    room     = job_r.is_control ? CNT_W'(MAX_RESULTS - 1) : CNT_W'(MAX_RESULTS);
    n_inc    = n + CNT_W'(1);
    more     = (done < job_r.data_len) && (n < room);
    rem      = job_r.data_len - done;
    // bytes reachable within the page window from the current offset
    span     = SPAN_W'(SPAN_MAX) - SPAN_W'(cur_addr[PAGE_BITS-1:0]);
    rem_fits = (CMP_W'(rem) <= CMP_W'(span));

    // trim to whole packets unless the rest fits or one packet exceeds the window
    len      = l0 - (((!fits) && (div_quo != '0)) ? SPAN_W'(div_rem) : SPAN_W'(0));
    if (fits) begin
      odd = div_quo[0] ^ (div_rem != '0);
    end else begin
      odd = (div_quo != '0) ? div_quo[0] : 1'b1;
    end
    done_sum = done + LEN_BITS'(len);

    state_next      = state;
    job_r_next      = job_r;
    done_next       = done;
    n_next          = n;
    toggle_next     = toggle;
    cur_addr_next   = cur_addr;
    l0_next         = l0;
    fits_next       = fits;
    desc_valid_next = desc_valid && desc_stall;
    desc_next       = desc;
    q_pop           = 1'b0;
    div_start       = 1'b0;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          job_r_next    = q_job;
          done_next     = '0;
          n_next        = '0;
          toggle_next   = 1'b0;
          cur_addr_next = q_job.data_addr;
          state_next    = q_job.is_control ? S_SETUP : S_START;
        end
      end
      S_SETUP: begin
        if (out_free) begin
          desc_valid_next        = 1'b1;
          desc_next.pid_code     = PID_SETUP;
          desc_next.data_toggle  = 1'b0;
          desc_next.buffer_start = job_r.setup_addr;
          desc_next.byte_count   = BC_W'(SETUP_BYTES);
          desc_next.alt_link     = ALT_TERM;
          desc_next.last         = 1'b0;
          toggle_next            = 1'b1;
          n_next                 = n_inc;
          state_next             = S_START;
        end
      end
      S_START: begin
        if (more) begin
          fits_next  = rem_fits;
          l0_next    = rem_fits ? SPAN_W'(rem) : span;
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = job_r.is_control ? S_STATUS : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          desc_valid_next        = 1'b1;
          desc_next.pid_code     = job_r.is_in ? PID_IN : PID_OUT;
          desc_next.data_toggle  = toggle;
          desc_next.buffer_start = cur_addr;
          desc_next.byte_count   = BC_W'(len);
          desc_next.alt_link     = job_r.alt_link;
          desc_next.last         = !job_r.is_control &&
                                   ((done_sum >= job_r.data_len) || (n_inc >= room));
          toggle_next            = toggle ^ odd;
          done_next              = done_sum;
          cur_addr_next          = cur_addr + ADDR_W'(len);
          n_next                 = n_inc;
          state_next             = S_START;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          desc_valid_next        = 1'b1;
          desc_next.pid_code     = job_r.is_in ? PID_OUT : PID_IN;
          desc_next.data_toggle  = 1'b1;
          desc_next.buffer_start = '0;
          desc_next.byte_count   = '0;
          desc_next.alt_link     = ALT_TERM;
          desc_next.last         = 1'b1;
          n_next                 = n_inc;
          state_next             = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      n          <= '0;
      toggle     <= 1'b0;
      desc_valid <= 1'b0;
    end else begin
      state      <= state_next;
      n          <= n_next;
      toggle     <= toggle_next;
      desc_valid <= desc_valid_next;
      job_r      <= job_r_next;
      done       <= done_next;
      cur_addr   <= cur_addr_next;
      l0         <= l0_next;
      fits       <= fits_next;
      desc       <= desc_next;
    end
  end

  `UTDS_ASSERT_ALWAYS(a_done_in_range, clk, rst, (state == S_IDLE) || (done <= job_r.data_len), "data offset past request length")
  `UTDS_ASSERT_ALWAYS(a_count_in_range, clk, rst, n <= CNT_W'(MAX_RESULTS), "descriptor count past limit")
  `UTDS_ASSERT_IMP(a_setup_not_last, clk, rst, desc_valid && (desc.pid_code == PID_SETUP), !desc.last, "setup descriptor marked last")
  `UTDS_ASSERT_IMP(a_div_start_idle, clk, rst, div_start, !div_busy, "divider restarted while busy")

endmodule

/* design/usb_transfer_descriptor_splitter_core.sv */
// ----------------------------------------------------------------------------
// usb_transfer_descriptor_splitter_core
// Request in (req_valid/req_stall/req), one item per transfer request;
// descriptors out (desc_valid/desc_stall/desc), one item per descriptor, the
// final one flagged by desc.last. Non-control zero-length requests are
// accepted and give nothing. A front stage classifies and queues requests;
// the back sequencer runs one at a time. Output sits in one register.
// Each data descriptor is sized from the page window, divided bit-serially
// by max packet, then loaded into the output register. A control request
// emits setup before its data and, after the end-of-data check, status.
// A request gives at most 20 descriptors; a 1 KB control read gives three.
// Reset is synchronous, empties the queue and drops any pending descriptor.
// desc_stall holds the output register; requests keep queuing until full.
// ----------------------------------------------------------------------------
module usb_transfer_descriptor_splitter_core #(
  parameter int QUEUE_DEPTH = utds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  utds_pkg::in_item_t  req,
  output logic                desc_valid,
  input  logic                desc_stall,
  output utds_pkg::out_item_t desc
);
  import utds_pkg::*;

  // queue between classifier and sequencer
  logic q_valid;
  logic q_pop;
  job_t q_job;

  // front: drops empty bulk requests, fixes max packet 0 to 1, picks alt link
  utds_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_job)
  );

  // back: setup, page-window data chunks with toggle tracking, status
  utds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives transfer requests into the descriptor splitter and checks every
// descriptor it returns against an in-bench prediction of the same split:
// setup stage, page-window data descriptors with max-packet trimming and
// toggle tracking, and the status stage. Both handshakes idle at random, and
// one phase starves the output long enough to back the request side up.
// ----------------------------------------------------------------------------
module testbench;
  import utds_pkg::*;

  localparam int CYCLE_LIMIT   = 1_200_000;
  localparam int DRAIN_CYCLES  = 600;   // a full 20-descriptor request, with room
  localparam int PRINT_CAP     = 40;
  localparam int LONG_HOLD     = 800;   // output starvation in the pressure phase
  localparam int RANDOM_ITEMS  = 380;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid;
  logic      req_stall;
  in_item_t  req;
  logic      desc_valid;
  logic      desc_stall;
  out_item_t desc;

  out_item_t expected_desc[$];   // descriptors predicted, oldest first
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  bit        idle_off       = 1'b0;   // both sides run without gaps while set
  int        desc_hold_cycles = 0;    // long output hold, picked up by the stall driver

  usb_transfer_descriptor_splitter_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .desc_valid(desc_valid),
    .desc_stall(desc_stall),
    .desc      (desc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d descriptors outstanding",
               cycle_count, expected_desc.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Bytes one descriptor takes from 'remaining' bytes at 'start': up to five
  // pages counted from the start offset; if the rest does not fit, cut back to
  // a whole number of packets unless that would leave less than one packet.
  function automatic logic [63:0] descriptor_span(input logic [63:0] start,
                                                  input logic [63:0] remaining,
                                                  input logic [63:0] mps);
    logic [63:0] span;
    logic [63:0] a;
    logic [63:0] room;
    int          i;
    span = '0;
    a    = start;
    for (i = 0; i <= LAST_BUFFER_INDEX; i++) begin
      room = 64'(PAGE_BYTES) - (a % 64'(PAGE_BYTES));
      if (span + room >= remaining) return remaining;
      span += room;
      a    += room;
    end
    if (span >= mps) span -= span % mps;
    return span;
  endfunction

  // Appends the descriptors one accepted request should produce.
  function automatic void predict_descriptors(input in_item_t r);
    logic [63:0] mps;
    logic [63:0] dlen;
    logic [63:0] done;
    logic [63:0] len;
    logic [63:0] pkts;
    logic        toggle;
    logic [1:0]  alt;
    int          n;
    int          room_left;
    out_item_t   d;
    mps  = (r.max_packet == '0) ? 64'd1 : 64'(r.max_packet);
    dlen = 64'(r.data_len);
    if (!r.is_control && dlen == 0) return;
    alt       = !r.is_in ? ALT_TERM : (r.is_control ? ALT_STATUS : ALT_STOP);
    n         = 0;
    toggle    = 1'b0;
    done      = '0;
    // a control request keeps one slot for its status stage
    room_left = r.is_control ? MAX_RESULTS - 1 : MAX_RESULTS;
    if (r.is_control) begin
      d.pid_code     = PID_SETUP;
      d.data_toggle  = 1'b0;
      d.buffer_start = r.setup_addr;
      d.byte_count   = BC_W'(descriptor_span(r.setup_addr, 64'(SETUP_BYTES), mps));
      d.alt_link     = ALT_TERM;
      d.last         = 1'b0;
      expected_desc.push_back(d);
      n++;
      toggle = 1'b1;
    end
    while (done < dlen && n < room_left) begin
      len = descriptor_span(r.data_addr + done, dlen - done, mps);
      if (len == 0) len = dlen - done;
      d.pid_code     = r.is_in ? PID_IN : PID_OUT;
      d.data_toggle  = toggle;
      d.buffer_start = r.data_addr + done;
      d.byte_count   = BC_W'(len);
      d.alt_link     = alt;
      d.last         = 1'b0;
      expected_desc.push_back(d);
      n++;
      // odd packet count leaves the toggle flipped for the next descriptor
      pkts = (len + mps - 1) / mps;
      if (pkts[0]) toggle = ~toggle;
      done += len;
    end
    if (r.is_control) begin
      // status runs opposite to the data direction, always toggle 1
      d.pid_code     = r.is_in ? PID_OUT : PID_IN;
      d.data_toggle  = 1'b1;
      d.buffer_start = '0;
      d.byte_count   = '0;
      d.alt_link     = ALT_TERM;
      d.last         = 1'b0;
      expected_desc.push_back(d);
      n++;
    end
    if (n > 0) begin
      d = expected_desc.pop_back();
      d.last = 1'b1;
      expected_desc.push_back(d);
    end
  endfunction

  // Descriptor checker: every accepted descriptor against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && desc_valid && !desc_stall) begin
      if (expected_desc.size() == 0) begin
        flag_mismatch("descriptor with none expected", desc.buffer_start, '0);
      end else begin
        want = expected_desc.pop_front();
        if (desc.pid_code != want.pid_code)
          flag_mismatch("pid_code", desc.pid_code, want.pid_code);
        if (desc.data_toggle != want.data_toggle)
          flag_mismatch("data_toggle", desc.data_toggle, want.data_toggle);
        if (desc.buffer_start != want.buffer_start)
          flag_mismatch("buffer_start", desc.buffer_start, want.buffer_start);
        if (desc.byte_count != want.byte_count)
          flag_mismatch("byte_count", desc.byte_count, want.byte_count);
        if (desc.alt_link != want.alt_link)
          flag_mismatch("alt_link", desc.alt_link, want.alt_link);
        if (desc.last != want.last)
          flag_mismatch("last", desc.last, want.last);
      end
    end
  end

  // Output stall driver: a random hold before each descriptor, and the one
  // long hold when the pressure phase asks for it.
  initial begin : desc_stall_driver
    int waits;
    desc_stall = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (desc_hold_cycles != 0) begin
        desc_stall <= 1'b1;
        repeat (desc_hold_cycles) @(negedge clk);
        desc_hold_cycles = 0;
      end
      waits = idle_off ? 0 : $urandom_range(0, 8);
      if (waits != 0) begin
        desc_stall <= 1'b1;
        repeat (waits) @(negedge clk);
      end
      desc_stall <= 1'b0;
      do @(posedge clk); while (!(desc_valid && !desc_stall));
      @(negedge clk);
    end
  end

  // Offers one request after a random gap; predicts on acceptance. Valid is
  // left high on return so a back-to-back item needs no drop.
  task automatic send_request(input in_item_t r);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_descriptors(r);
    @(negedge clk);
  endtask

  function automatic in_item_t make_request(input logic ctrl, input logic dir_in,
                                            input logic [63:0] setup,
                                            input logic [63:0] data,
                                            input int len, input int mp);
    in_item_t r;
    r.is_control = ctrl;
    r.is_in      = dir_in;
    r.setup_addr = setup;
    r.data_addr  = data;
    r.data_len   = LEN_BITS'(len);
    r.max_packet = MP_W'(mp);
    return r;
  endfunction

  function automatic in_item_t random_request();
    in_item_t r;
    int       pick;
    r.is_control = 1'($urandom_range(0, 1));
    r.is_in      = 1'($urandom_range(0, 1));
    r.setup_addr = {$urandom, $urandom};
    r.data_addr  = {$urandom, $urandom};
    // start close to a page end now and then to stress the window edge
    if ($urandom_range(0, 9) < 3)
      r.data_addr[PAGE_BITS-1:0] = PAGE_BITS'(PAGE_BYTES - $urandom_range(1, 16));
    // mostly short transfers; long ones cost up to twenty descriptors
    pick = $urandom_range(0, 99);
    if (pick < 10)      r.data_len = '0;
    else if (pick < 55) r.data_len = LEN_BITS'($urandom_range(1, 4096));
    else if (pick < 80) r.data_len = LEN_BITS'($urandom_range(4097, 65535));
    else                r.data_len = LEN_BITS'($urandom_range(65536, 262143));
    pick = $urandom_range(0, 99);
    if (pick < 3)       r.max_packet = '0;
    else if (pick < 5)  r.max_packet = MP_W'($urandom_range(1025, 2047));
    else if (pick < 70) r.max_packet = MP_W'(8 << $urandom_range(0, 7));
    else                r.max_packet = MP_W'($urandom_range(1, 1024));
    return r;
  endfunction

  // Corners: empty requests, control without data, window edges, exact fits,
  // address wrap, zero and oversize max packet, long odd-packet runs.
  task automatic test_directed_cases();
    send_request(make_request(0, 0, '0, '0, 0, 64));
    send_request(make_request(0, 1, '1, '1, 0, 1024));
    send_request(make_request(1, 0, 64'h1000, '0, 0, 64));
    send_request(make_request(1, 1, 64'hFFFF_FFFF_FFFF_FFF8, '0, 0, 8));
    send_request(make_request(1, 1, '1, 64'h1_0000, 1, 64));
    send_request(make_request(1, 0, 64'h2000, 64'h3000, 1024, 64));
    send_request(make_request(0, 1, '0, '0, 262143, 1024));
    send_request(make_request(0, 0, '0, 64'hFFF, 262143, 512));
    send_request(make_request(0, 1, '0, '1, 262143, 1));
    send_request(make_request(0, 0, '0, 64'h123, 3000, 0));
    send_request(make_request(0, 1, '0, 64'h4000, 20480, 1024));
    send_request(make_request(0, 1, '0, 64'h4000, 20481, 1024));
    send_request(make_request(1, 1, 64'h5555_5555_5555_5555, 64'h164, 100000, 1023));
    send_request(make_request(1, 1, '0, 64'hFFF, 262143, 2047));
    send_request(make_request(0, 0, '0, 64'h7FF, 262143, 1500));
    send_request(make_request(0, 0, '0, '0, 1, 1));
    send_request(make_request(1, 0, 64'hAAAA_AAAA_AAAA_AAAA,
                              64'h8000_0000_0000_0003, 50000, 7));
    send_request(make_request(0, 1, '0, 64'hFFF, 16385, 1));
    send_request(make_request(0, 1, '0, 64'hFFF, 16386, 64));
    send_request(make_request(1, 0, 64'h5555_5555_5555_5555,
                              64'hAAAA_AAAA_AAAA_AAAA, 131072, 16));
  endtask

  // Starve the output while requests keep coming, so the queue fills and the
  // request side stalls.
  task automatic test_output_backpressure();
    in_item_t r;
    int       k;
    idle_off = 1'b1;
    desc_hold_cycles = LONG_HOLD;
    for (k = 0; k < 10; k++) begin
      r = random_request();
      r.is_control = 1'b1;   // every item yields descriptors
      send_request(r);
    end
    idle_off = 1'b0;
  endtask

  task automatic test_random_requests(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      idle_off = (k >= 150 && k < 200);   // one gap-free stretch
      send_request(random_request());
    end
    idle_off = 1'b0;
  endtask

  initial begin
    req_valid = 1'b0;
    req       = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_output_backpressure();
    test_random_requests(RANDOM_ITEMS);
    req_valid <= 1'b0;
    while (expected_desc.size() != 0) @(posedge clk);
    // keep the checker running so that any descriptor with none expected is flagged
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
